>>> rtl/fqps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqps_pkg
// Types and codes shared by the ordered queue with promote and search.
// ----------------------------------------------------------------------------
package fqps_pkg;

    localparam int OP_W  = 3;
    localparam int ID_W  = 16;
    localparam int AGE_W = 8;
    localparam int ST_W  = 3;
    localparam int OCC_W = 5;

    localparam logic [OP_W-1:0] OP_ENQ     = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ     = 3'd1;
    localparam logic [OP_W-1:0] OP_PROMOTE = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_MOVED = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  key_id;
        logic [AGE_W-1:0] age_in;
    } fqps_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  out_id;
        logic [AGE_W-1:0] out_age;
        logic [OCC_W-1:0] occupancy;
    } fqps_rsp_t;

endpackage

>>> rtl/fqps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqps_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/fqps_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqps_seq
// Sequencer: circular buffer pointers, entry scan, shift for promote.
// ----------------------------------------------------------------------------
module fqps_seq
    import fqps_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fqps_req_t                     req,
    output logic                          res_valid,
    input  logic                          res_ready,
    output fqps_rsp_t                     res,
    output logic                          we,
    output logic [$clog2(DEPTH)-1:0]      waddr,
    output logic [ID_BITS+AGE_W-1:0]      wdata,
    output logic [$clog2(DEPTH)-1:0]      raddr,
    input  logic [ID_BITS+AGE_W-1:0]      rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int KW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int OW = (CW < OCC_W) ? CW : OCC_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SH_RD = 7'b0001000,
        S_SH_WR = 7'b0010000,
        S_FRONT = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic [AGE_W-1:0]     age_reg, age_next;
    logic [ST_W-1:0]      status_reg, status_next;
    logic [ID_BITS-1:0]   rid_reg, rid_next;
    logic [AGE_W-1:0]     rage_reg, rage_next;

    logic                 req_fire;
    logic [ID_BITS-1:0]   key_w;
    logic [ID_BITS-1:0]   r_id;
    logic [AGE_W-1:0]     r_age;
    logic                 full;
    logic [CW-1:0]        lidx;
    logic [SW-1:0]        psum;
    logic [AW-1:0]        addr;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign key_w     = ID_BITS'(req.key_id[KW-1:0]);
    assign r_id      = rdata[ID_BITS+AGE_W-1:AGE_W];
    assign r_age     = rdata[AGE_W-1:0];
    assign full      = (count_reg == CW'(DEPTH));

    // logical slot to physical address
    always_comb
    begin
        psum = SW'(head_reg) + SW'(lidx);
        if (psum >= SW'(DEPTH))
        begin
            psum = psum - SW'(DEPTH);
        end
        addr = psum[AW-1:0];
    end

    assign waddr = addr;
    assign raddr = addr;

    assign res_valid     = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.out_id    = ID_W'(rid_reg[KW-1:0]);
    assign res.out_age   = rage_reg;
    assign res.occupancy = OCC_W'(count_reg[OW-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        age_next    = age_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        rage_next   = rage_reg;
        we          = 1'b0;
        wdata       = rdata;
        lidx        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                lidx = count_reg;
                if (req_fire)
                begin
                    op_next     = req.op;
                    key_next    = key_w;
                    age_next    = req.age_in;
                    status_next = ST_OK;
                    rid_next    = '0;
                    rage_next   = '0;
                    state_next  = S_DONE;
                    case (req.op)
                        OP_ENQ:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                wdata      = {key_w, req.age_in};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        OP_PROMOTE:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                status_next = ST_NOT_MOVED;
                            end
                            else
                            begin
                                idx_next   = CW'(1);
                                state_next = S_READ;
                            end
                        end
                        OP_SEARCH, OP_UPDATE:
                        begin
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (idx_reg >= count_reg)
                begin
                    status_next = (op_reg == OP_PROMOTE) ? ST_NOT_MOVED : ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (op_reg == OP_DEQ)
                begin
                    rid_next   = r_id;
                    rage_next  = r_age;
                    head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else if (r_id == key_reg)
                begin
                    rid_next = r_id;
                    case (op_reg)
                        OP_UPDATE:
                        begin
                            we         = 1'b1;
                            wdata      = {r_id, age_reg};
                            rage_next  = age_reg;
                            state_next = S_DONE;
                        end
                        OP_PROMOTE:
                        begin
                            rage_next  = r_age;
                            state_next = S_SH_RD;
                        end
                        default:
                        begin
                            rage_next  = r_age;
                            state_next = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_SH_RD:
            begin
                lidx       = idx_reg - 1'b1;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                we       = 1'b1;
                wdata    = rdata;
                idx_next = idx_reg - 1'b1;
                state_next = (idx_reg == CW'(1)) ? S_FRONT : S_SH_RD;
            end
            S_FRONT:
            begin
                lidx       = '0;
                we         = 1'b1;
                wdata      = {rid_reg, rage_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        age_reg    <= age_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rage_reg   <= rage_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer out of range");

    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.op == OP_ENQ && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not grow the queue");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !((req_fire && req.op == OP_ENQ) || (state_reg == S_CHECK && op_reg == OP_DEQ))
        |=> $stable(count_reg))
        else $error("entry count changed without enqueue or dequeue");

endmodule

>>> rtl/fifo_queue_with_promote_and_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_promote_and_search_core
// Bounded ordered queue with promote-to-front, search and age update.
// ----------------------------------------------------------------------------
// Enqueue, dequeue-empty and rejected ops answer without a scan. Search and
//   update scan from the head, promote from the second entry; a miss scans
//   every held entry that the scan covers.
// Each entry costs one RAM read and one compare; promote adds one
//   read/write pair per entry moved. One request in flight at a time.
// Reset empties the queue at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_queue_with_promote_and_search_core
    import fqps_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  fqps_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output fqps_rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int DW = ID_BITS + AGE_W;

    logic          res_valid;
    logic          res_ready;
    fqps_rsp_t     res;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;

    logic          rsp_valid_reg;
    fqps_rsp_t     rsp_reg;

    fqps_seq #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    fqps_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // hold the result until taken
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> test/fifo_queue_with_promote_and_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_promote_and_search_core_tb
// Drives requests into the ordered queue and checks every response against a
// queue model kept in the bench. Directed tests cover the empty, single-entry
// and full queue, the promote matching rules and unused opcodes. They are
// followed by a long output stall and by random phases that fill, drain and
// churn the queue. Keys come from small pools so that matches and duplicates
// are common. The sender idles in bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module fifo_queue_with_promote_and_search_core_tb;
    import fqps_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int KEY_BITS     = 16;
    localparam logic [ID_W-1:0] KEY_MASK = ID_W'((64'd1 << KEY_BITS) - 1);
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_UPDATE + 3'd1;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int RANDOM_REQUESTS = 1770;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 120;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    fqps_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    fqps_rsp_t rsp;

    // queue model
    logic [ID_W-1:0]  model_ids  [QUEUE_DEPTH];
    logic [AGE_W-1:0] model_ages [QUEUE_DEPTH];
    int               model_held = 0;

    fqps_rsp_t expected_rsp[$];
    int        errors      = 0;
    int        burst_left  = 0;
    int        idle_cycles = 0;
    int        hold_asked  = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;
    int        stall_mode  = 0;
    int        mode_left   = 0;

    fifo_queue_with_promote_and_search_core #(
        .DEPTH   (QUEUE_DEPTH),
        .ID_BITS (KEY_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic fqps_rsp_t apply_queue_op(input fqps_req_t r);
        fqps_rsp_t        o;
        logic [ID_W-1:0]  key;
        logic [ID_W-1:0]  hit_id;
        logic [AGE_W-1:0] hit_age;
        int               hit;
        int               i;
        o   = '0;
        key = r.key_id & KEY_MASK;
        hit = model_held;
        for (i = (r.op == OP_PROMOTE) ? 1 : 0; i < model_held && hit == model_held; i++)
        begin
            if (model_ids[i] == key)
                hit = i;
        end
        case (r.op)
            OP_ENQ:
            begin
                if (model_held >= QUEUE_DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    model_ids[model_held]  = key;
                    model_ages[model_held] = r.age_in;
                    model_held++;
                end
            end
            OP_DEQ:
            begin
                if (model_held == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.out_id  = model_ids[0];
                    o.out_age = model_ages[0];
                    for (i = 1; i < model_held; i++)
                    begin
                        model_ids[i-1]  = model_ids[i];
                        model_ages[i-1] = model_ages[i];
                    end
                    model_held--;
                end
            end
            OP_PROMOTE:
            begin
                if (model_held < 2 || hit >= model_held)
                    o.status = ST_NOT_MOVED;
                else
                begin
                    hit_id  = model_ids[hit];
                    hit_age = model_ages[hit];
                    for (i = hit; i > 0; i--)
                    begin
                        model_ids[i]  = model_ids[i-1];
                        model_ages[i] = model_ages[i-1];
                    end
                    model_ids[0]  = hit_id;
                    model_ages[0] = hit_age;
                    o.out_id      = hit_id;
                    o.out_age     = hit_age;
                end
            end
            OP_SEARCH, OP_UPDATE:
            begin
                if (hit >= model_held)
                    o.status = ST_NOT_FOUND;
                else
                begin
                    if (r.op == OP_UPDATE)
                        model_ages[hit] = r.age_in;
                    o.out_id  = model_ids[hit];
                    o.out_age = model_ages[hit];
                end
            end
            default:
            begin
            end
        endcase
        o.occupancy = OCC_W'(model_held);
        return o;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                                input logic [AGE_W-1:0] age);
        fqps_req_t r;
        int        gap;
        r = '{op: op, key_id: key, age_in: age};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        expected_rsp.push_back(apply_queue_op(r));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_request(OP_DEQ, 16'h0000, 8'h00);
        send_request(OP_PROMOTE, 16'hFFFF, 8'hFF);
        send_request(OP_SEARCH, 16'h0000, 8'h00);
        send_request(OP_UPDATE, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_single_entry();
        send_request(OP_ENQ, 16'h5A5A, 8'h00);
        send_request(OP_PROMOTE, 16'h5A5A, 8'h00);
    endtask

    task automatic test_full_queue();
        int               k;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        for (k = 0; k < QUEUE_DEPTH - 1; k++)
        begin
            id  = (k == 0 || k == 9) ? 16'hFFFF : (k == 1) ? 16'h0000 : ID_W'($urandom);
            age = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : AGE_W'($urandom);
            send_request(OP_ENQ, id, age);
        end
        send_request(OP_ENQ, 16'h1234, 8'h77);
    endtask

    task automatic test_match_rules();
        send_request(OP_PROMOTE, 16'h5A5A, 8'h00);
        send_request(OP_PROMOTE, 16'hFFFF, 8'h00);
        send_request(OP_PROMOTE, 16'hFFFF, 8'h00);
        send_request(OP_SEARCH, 16'hFFFF, 8'h00);
        send_request(OP_UPDATE, 16'h0000, 8'hFF);
        send_request(OP_UNUSED_LAST, 16'hFFFF, 8'hFF);
        send_request(OP_DEQ, 16'h0000, 8'h00);
    endtask

    task automatic test_output_backpressure();
        int k;
        hold_asked <= hold_asked + 1;
        for (k = 0; k < 10; k++)
            send_request(($urandom_range(0, 1) == 0) ? OP_ENQ : OP_SEARCH,
                         ID_W'($urandom_range(0, 3)), AGE_W'($urandom));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [ID_W-1:0]  key_pool [6];
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  key;
        int               sent;
        int               phase_len;
        int               enq_pct;
        int               deq_pct;
        int               pick;
        int               k;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            for (k = 0; k < 6; k++)
                key_pool[k] = ID_W'($urandom);
            if ($urandom_range(0, 7) == 0)
                key_pool[0] = '1;
            case ($urandom_range(0, 2))
                0:
                begin
                    enq_pct = 45;
                    deq_pct = 10;
                end
                1:
                begin
                    enq_pct = 15;
                    deq_pct = 35;
                end
                default:
                begin
                    enq_pct = 28;
                    deq_pct = 25;
                end
            endcase
            phase_len = $urandom_range(40, 150);
            for (k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < enq_pct)
                    op = OP_ENQ;
                else if (pick < enq_pct + deq_pct)
                    op = OP_DEQ;
                else if (pick >= 97)
                    op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_PROMOTE;
                        1:       op = OP_SEARCH;
                        default: op = OP_UPDATE;
                    endcase
                end
                key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 5)]
                                                   : ID_W'($urandom);
                send_request(op, key, AGE_W'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
    endtask

    // receiver: stall pattern plus requested long hold
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 300);
        end
        else
            mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= 1'($urandom_range(0, 1));
                default: rsp_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_rsp
        fqps_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch($sformatf("unexpected response status=%0d id=%h age=%h occ=%0d",
                                          rsp.status, rsp.out_id, rsp.out_age, rsp.occupancy));
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, want.status));
                if (rsp.out_id !== want.out_id)
                    report_mismatch($sformatf("out_id got %h want %h",
                                              rsp.out_id, want.out_id));
                if (rsp.out_age !== want.out_age)
                    report_mismatch($sformatf("out_age got %h want %h",
                                              rsp.out_age, want.out_age));
                if (rsp.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              rsp.occupancy, want.occupancy));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_single_entry();
        test_full_queue();
        test_match_rules();
        test_output_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/fqps_pkg.sv
rtl/fqps_ram.sv
rtl/fqps_seq.sv
rtl/fifo_queue_with_promote_and_search_core.sv
test/fifo_queue_with_promote_and_search_core_tb.sv
